>>> hw/rtl/dbs_pkg.sv
// shared constants and types for the elevation grid sampler
package dbs_pkg;

    localparam int MaxGridW = 256;
    localparam int MaxGridH = 256;
    localparam int ColW     = $clog2(MaxGridW);
    localparam int RowW     = $clog2(MaxGridH);
    localparam int AddrW    = ColW + RowW;
    localparam int SizeW    = 9;

    localparam logic [2:0] RegOriginX   = 3'd0;
    localparam logic [2:0] RegOriginY   = 3'd1;
    localparam logic [2:0] RegInvStepX  = 3'd2;
    localparam logic [2:0] RegInvStepY  = 3'd3;
    localparam logic [2:0] RegGridW     = 3'd4;
    localparam logic [2:0] RegGridH     = 3'd5;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpSample = 1'b1;

    typedef struct packed {
        logic [31:0] height;
        logic        ok;
    } dbs_cell_t;

endpackage

>>> hw/rtl/dbs_store.sv
// grid store: elevation and valid memories with a clearing sweep of the valid bits
module dbs_store
    import dbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [AddrW-1:0]    wr_addr,
    input  dbs_cell_t           wr_data,
    input  logic                rd_en,
    input  logic [AddrW-1:0]    rd_addr,
    output dbs_cell_t           rd_data,
    output logic                busy
);

    logic [31:0]      height_mem [MaxGridW*MaxGridH];
    logic             valid_mem  [MaxGridW*MaxGridH];
    logic [AddrW:0]   clr_reg;
    logic [AddrW:0]   clr_next;

    assign busy     = ~clr_reg[AddrW];
    assign clr_next = clr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (busy) begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            height_mem[wr_addr] <= wr_data.height;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy) begin
            valid_mem[clr_reg[AddrW-1:0]] <= 1'b0;
        end else if (wr_en) begin
            valid_mem[wr_addr] <= wr_data.ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data.height <= height_mem[rd_addr];
            rd_data.ok     <= valid_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/dem_bilinear_sampler_core.sv
// top level of the elevation grid sampler
// A load item is written straight into the grid store when it is accepted. A sample item is
// worked through before the next item is accepted: x and then y are mapped to a grid position,
// the bounds are checked and the neighbours and weights worked out, and each of the four
// neighbours then goes through a store read, weight product, weight times elevation and
// accumulate step. A last step hands the result to the output register. The nearest-cell
// fallback adds a read of the nearest cell. A sample outside the grid skips the reads. A
// result still waiting in the output register holds the sample in its last step until that
// result is taken. After reset the valid bits are swept clear, and no item is accepted until
// the sweep ends.
module dem_bilinear_sampler_core
    import dbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [7:0]         s_cell_col,
    input  logic [7:0]         s_cell_row,
    input  logic signed [31:0] s_cell_height,
    input  logic               s_cell_ok,
    input  logic signed [31:0] s_query_x,
    input  logic signed [31:0] s_query_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic               m_used_nearest,
    output logic signed [31:0] m_height_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAPX, S_MAPY, S_BOUND, S_RD, S_MUL1, S_MUL2, S_ACC,
        S_NEAR_RD, S_NEAR, S_OUT
    } state_t;

    logic signed [31:0] org_x_reg, org_y_reg, inv_x_reg, inv_y_reg;
    logic [SizeW-1:0]   gw_reg, gh_reg;

    state_t             state_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic signed [57:0] gx_reg, gy_reg;
    logic [ColW-1:0]    x0_reg, x1_reg, nx_reg;
    logic [RowW-1:0]    y0_reg, y1_reg, ny_reg;
    logic [16:0]        fx_reg, fy_reg;
    logic [1:0]         k_reg;
    logic               all_ok_reg;
    logic signed [31:0] z_reg;
    logic [33:0]        w_reg;
    logic signed [65:0] p_reg;
    logic signed [67:0] acc_reg;
    logic               hit_reg, near_reg;
    logic signed [31:0] out_reg;
    logic               ovalid_reg;

    dbs_cell_t          rd_data;
    logic               busy;
    logic               rd_en;
    logic [AddrW-1:0]   rd_addr;
    logic               load_fire;

    // effective grid size
    logic [SizeW-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = (gw_reg == '0) ? SizeW'(1)
              : (gw_reg > SizeW'(MaxGridW) ? SizeW'(MaxGridW) : gw_reg);
        h_eff = (gh_reg == '0) ? SizeW'(1)
              : (gh_reg > SizeW'(MaxGridH) ? SizeW'(MaxGridH) : gh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            inv_x_reg <= 32'sd65536;
            inv_y_reg <= 32'sd65536;
            gw_reg    <= SizeW'(256);
            gh_reg    <= SizeW'(256);
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegOriginX:  org_x_reg <= cfg_data;
                RegOriginY:  org_y_reg <= cfg_data;
                RegInvStepX: inv_x_reg <= cfg_data;
                RegInvStepY: inv_y_reg <= cfg_data;
                RegGridW:    gw_reg    <= cfg_data[SizeW-1:0];
                RegGridH:    gh_reg    <= cfg_data[SizeW-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE) && !busy;
    assign load_fire = s_valid && s_ready && (s_op == OpLoad);

    // grid position, 16 fraction bits, rounded to nearest
    function automatic logic signed [57:0] map_pos(input logic signed [31:0] q,
                                                   input logic signed [31:0] org,
                                                   input logic signed [31:0] inv);
        logic signed [32:0] d;
        logic signed [65:0] p;
        begin
            d = 33'(q) - 33'(org);
            p = 66'(d) * 66'(inv) + 66'sd128;
            map_pos = 58'(p >>> 8);
        end
    endfunction

    // clamp floor index to [0, n-1]
    function automatic logic [8:0] clamp_idx(input logic signed [25:0] v,
                                             input logic [SizeW-1:0] n);
        begin
            if (v < 0) clamp_idx = '0;
            else if (v > 26'(n) - 26'sd1) clamp_idx = 9'(n - 1'b1);
            else clamp_idx = 9'(v);
        end
    endfunction

    logic signed [57:0] lim_x, lim_y;
    logic signed [57:0] gxh, gyh;
    logic [8:0]         cx0, cy0, cnx, cny;
    logic signed [42:0] fxr, fyr;
    logic               outside;
    always_comb begin
        lim_x   = (58'(w_eff) <<< 16) - 58'sd32768;
        lim_y   = (58'(h_eff) <<< 16) - 58'sd32768;
        outside = (gx_reg < -58'sd32768) || (gy_reg < -58'sd32768) ||
                  (gx_reg > lim_x) || (gy_reg > lim_y);
        gxh = gx_reg + 58'sd32768;
        gyh = gy_reg + 58'sd32768;
        cx0 = clamp_idx(26'(gx_reg >>> 16), w_eff);
        cy0 = clamp_idx(26'(gy_reg >>> 16), h_eff);
        cnx = clamp_idx(26'(gxh >>> 16), w_eff);
        cny = clamp_idx(26'(gyh >>> 16), h_eff);
        fxr = 43'(gx_reg) - (43'(cx0) <<< 16);
        fyr = 43'(gy_reg) - (43'(cy0) <<< 16);
    end

    // neighbour address for read k, or the nearest cell's address in the fallback read
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {y0_reg, x0_reg};
        if (state_reg == S_RD) begin
            rd_en = 1'b1;
            case (k_reg)
                2'd0:    rd_addr = {y0_reg, x0_reg};
                2'd1:    rd_addr = {y0_reg, x1_reg};
                2'd2:    rd_addr = {y1_reg, x0_reg};
                default: rd_addr = {y1_reg, x1_reg};
            endcase
        end else if (state_reg == S_NEAR_RD) begin
            rd_en   = 1'b1;
            rd_addr = {ny_reg, nx_reg};
        end
    end

    dbs_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_fire),
        .wr_addr ({s_cell_row, s_cell_col}),
        .wr_data ({s_cell_height, s_cell_ok}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (busy)
    );

    logic [16:0] wxa, wya;
    always_comb begin
        wxa = k_reg[0] ? fx_reg : 17'd65536 - fx_reg;
        wya = k_reg[1] ? fy_reg : 17'd65536 - fy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready && s_op == OpSample) begin
                        qx_reg    <= s_query_x;
                        qy_reg    <= s_query_y;
                        state_reg <= S_MAPX;
                    end
                end
                S_MAPX: begin
                    gx_reg    <= map_pos(qx_reg, org_x_reg, inv_x_reg);
                    state_reg <= S_MAPY;
                end
                S_MAPY: begin
                    gy_reg    <= map_pos(qy_reg, org_y_reg, inv_y_reg);
                    state_reg <= S_BOUND;
                end
                S_BOUND: begin
                    x0_reg     <= cx0[ColW-1:0];
                    y0_reg     <= cy0[RowW-1:0];
                    x1_reg     <= (10'(cx0) + 10'd1 < 10'(w_eff)) ? ColW'(cx0 + 9'd1)
                                                                  : ColW'(w_eff - 1'b1);
                    y1_reg     <= (10'(cy0) + 10'd1 < 10'(h_eff)) ? RowW'(cy0 + 9'd1)
                                                                  : RowW'(h_eff - 1'b1);
                    nx_reg     <= cnx[ColW-1:0];
                    ny_reg     <= cny[RowW-1:0];
                    fx_reg     <= (fxr < 0) ? 17'd0
                                : (fxr > 43'sd65536 ? 17'd65536 : 17'(fxr));
                    fy_reg     <= (fyr < 0) ? 17'd0
                                : (fyr > 43'sd65536 ? 17'd65536 : 17'(fyr));
                    k_reg      <= 2'd0;
                    all_ok_reg <= 1'b1;
                    acc_reg    <= '0;
                    hit_reg    <= 1'b0;
                    near_reg   <= 1'b0;
                    out_reg    <= '0;
                    state_reg  <= outside ? S_OUT : S_RD;
                end
                S_RD: begin
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    // weight product, then weight times elevation
                    all_ok_reg <= all_ok_reg & rd_data.ok;
                    z_reg      <= rd_data.height;
                    w_reg      <= 34'(wxa) * 34'(wya);
                    state_reg  <= S_MUL2;
                end
                S_MUL2: begin
                    p_reg     <= 66'(signed'({1'b0, w_reg})) * 66'(z_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_reg + 68'(p_reg);
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg != 2'd3) begin
                        state_reg <= S_RD;
                    end else if (all_ok_reg) begin
                        hit_reg   <= 1'b1;
                        out_reg   <= 32'((acc_reg + 68'(p_reg) + 68'sd2147483648) >>> 32);
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_NEAR_RD;
                    end
                end
                S_NEAR_RD: begin
                    state_reg <= S_NEAR;
                end
                S_NEAR: begin
                    if (rd_data.ok) begin
                        hit_reg  <= 1'b1;
                        near_reg <= 1'b1;
                        out_reg  <= rd_data.height;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!ovalid_reg || m_ready) begin
                        m_hit          <= hit_reg;
                        m_used_nearest <= near_reg;
                        m_height_out   <= out_reg;
                        ovalid_reg     <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (ovalid_reg && m_ready && !(state_reg == S_OUT)) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = ovalid_reg;

endmodule

>>> verif/dem_bilinear_sampler_core_tb.sv
// testbench for the elevation grid sampler: directed and random loads and samples
module dem_bilinear_sampler_core_tb;
    import dbs_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [7:0]         s_cell_col = '0;
    logic [7:0]         s_cell_row = '0;
    logic signed [31:0] s_cell_height = '0;
    logic               s_cell_ok = 1'b0;
    logic signed [31:0] s_query_x = '0;
    logic signed [31:0] s_query_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic               m_used_nearest;
    logic signed [31:0] m_height_out;

    typedef struct packed {
        logic        hit;
        logic        used_nearest;
        logic [31:0] height;
    } sample_res_t;

    dem_bilinear_sampler_core uut (.*);

    always #5 aclk = ~aclk;

    // own copy of the grid and registers
    logic signed [63:0] org_x, org_y, inv_x, inv_y;
    int unsigned        size_w, size_h;
    logic signed [31:0] grid_z [0:65535];
    bit                 grid_ok [0:65535];

    sample_res_t expected_q[$];
    int  mismatches = 0;
    int  samples_seen = 0;
    int  loads_sent = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  long_gaps = 1'b1;

    function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] to_grid(input logic signed [31:0] q,
                                                    input logic signed [63:0] org,
                                                    input logic signed [63:0] inv);
        logic signed [63:0] d;
        d = 64'(q) - org;
        return floor_sh(d * inv + 64'sd128, 8);
    endfunction

    function automatic logic signed [63:0] clampi(input logic signed [63:0] v,
                                                   input logic signed [63:0] n);
        if (v < 0) return 0;
        return (v > n - 1) ? n - 1 : v;
    endfunction

    function automatic sample_res_t predict_sample(input logic signed [31:0] qx,
                                                    input logic signed [31:0] qy);
        sample_res_t r;
        logic signed [63:0] w, h, gx, gy, nx, ny, x0, y0, x1, y1, fx, fy, acc;
        int a00, a10, a01, a11, an;
        r = '0;
        w = (size_w == 0) ? 1 : (size_w > MaxGridW ? MaxGridW : size_w);
        h = (size_h == 0) ? 1 : (size_h > MaxGridH ? MaxGridH : size_h);
        gx = to_grid(qx, org_x, inv_x);
        gy = to_grid(qy, org_y, inv_y);
        if (gx < -32768 || gy < -32768 || gx > w * 65536 - 32768 || gy > h * 65536 - 32768)
            return r;
        nx = clampi(floor_sh(gx + 32768, 16), w);
        ny = clampi(floor_sh(gy + 32768, 16), h);
        x0 = clampi(floor_sh(gx, 16), w);
        y0 = clampi(floor_sh(gy, 16), h);
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        a00 = int'(y0 * MaxGridW + x0);
        a10 = int'(y0 * MaxGridW + x1);
        a01 = int'(y1 * MaxGridW + x0);
        a11 = int'(y1 * MaxGridW + x1);
        if (grid_ok[a00] && grid_ok[a10] && grid_ok[a01] && grid_ok[a11]) begin
            fx = gx - x0 * 65536;
            fy = gy - y0 * 65536;
            if (fx < 0) fx = 0;
            if (fx > 65536) fx = 65536;
            if (fy < 0) fy = 0;
            if (fy > 65536) fy = 65536;
            // weight products reach 2^32, so the full sum needs 64 bits
            acc = (65536 - fx) * (65536 - fy) * 64'(grid_z[a00]);
            acc += fx * (65536 - fy) * 64'(grid_z[a10]);
            acc += (65536 - fx) * fy * 64'(grid_z[a01]);
            acc += fx * fy * 64'(grid_z[a11]);
            r.hit = 1'b1;
            r.height = 32'(floor_sh(acc + 64'sd2147483648, 32));
            return r;
        end
        an = int'(ny * MaxGridW + nx);
        if (grid_ok[an]) begin
            r.hit = 1'b1;
            r.used_nearest = 1'b1;
            r.height = grid_z[an];
        end
        return r;
    endfunction

    // valid stays high when the next item follows at once
    task automatic sender_gap();
        int n;
        n = 0;
        if (long_gaps) begin
            n = $urandom_range(0, 99);
            if (n < 55) n = 0;
            else if (n < 95) n = $urandom_range(1, 3);
            else n = $urandom_range(10, 40);
        end
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                             input logic [31:0] z, input logic ok,
                             input logic [31:0] qx, input logic [31:0] qy);
        s_valid <= 1'b1;
        s_op <= op;
        s_cell_col <= col;
        s_cell_row <= row;
        s_cell_height <= z;
        s_cell_ok <= ok;
        s_query_x <= qx;
        s_query_y <= qy;
        do @(posedge aclk); while (!s_ready);
        if (op == OpLoad) begin
            grid_z[{row, col}] = z;
            grid_ok[{row, col}] = ok;
            loads_sent++;
        end else begin
            expected_q = {expected_q, predict_sample(qx, qy)};
        end
        sender_gap();
    endtask

    task automatic load_cell(input int col, input int row, input logic [31:0] z,
                             input logic ok);
        send_item(OpLoad, col[7:0], row[7:0], z, ok, $urandom, $urandom);
    endtask

    task automatic sample_at(input logic [31:0] qx, input logic [31:0] qy);
        send_item(OpSample, 8'($urandom), 8'($urandom), $urandom, 1'($urandom), qx, qy);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            RegOriginX:  org_x = 64'(signed'(val));
            RegOriginY:  org_y = 64'(signed'(val));
            RegInvStepX: inv_x = 64'(signed'(val));
            RegInvStepY: inv_y = 64'(signed'(val));
            RegGridW:    size_w = val[8:0];
            RegGridH:    size_h = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] ix, input logic [31:0] iy,
                            input logic [31:0] gw, input logic [31:0] gh);
        drain();
        write_reg(RegOriginX, ox);
        write_reg(RegOriginY, oy);
        write_reg(RegInvStepX, ix);
        write_reg(RegInvStepY, iy);
        write_reg(RegGridW, gw);
        write_reg(RegGridH, gh);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        set_grid(0, 0, 32'h0001_0000, 32'h0001_0000, 4, 4);
        sample_at(0, 0);                        // nothing loaded yet: miss
        load_cell(0, 0, 32'h7FFF_FFFF, 1);
        load_cell(1, 0, 32'h8000_0000, 1);
        load_cell(0, 1, 32'h0000_0100, 1);
        load_cell(1, 1, 32'hFFFF_FF00, 1);
        sample_at(32'h80, 32'h80);              // bilinear in the middle
        sample_at(0, 0);
        sample_at(32'hFFFF_FF80, 32'hFFFF_FF80); // half a cell below the grid
        sample_at(32'hFFFF_FF7F, 0);            // just beyond: miss
        load_cell(1, 1, 32'h1234_5678, 0);      // invalid load, nearest fallback
        sample_at(32'h40, 32'h40);
        sample_at(32'hC0, 32'hC0);              // nearest is the invalid cell: miss
        load_cell(3, 3, 32'h0000_0A00, 1);
        sample_at(32'h380, 32'h380);            // upper edge clamps
        sample_at(32'h381, 0);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        load_cell(255, 255, 32'hFFFF_FFFF, 1);  // store corner, outside used grid
        drain();
        // zero step and grid size zero
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(0, 0);
        set_grid(0, 0, 32'hFFFF_0000, 32'h8000_0000, 32'h1FF, 32'h100);
        sample_at(32'hFFFF_FF00, 0);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic random_phase(input int n_items, input int gw, input int gh,
                                input logic signed [31:0] ix, input logic signed [31:0] iy);
        logic [31:0] ox, oy;
        int k;
        ox = $urandom;
        oy = $urandom;
        set_grid(ox, oy, ix, iy, gw, gh);
        for (k = 0; k < n_items; k++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                load_cell($urandom_range(0, gw > 0 ? gw - 1 : 0),
                          $urandom_range(0, gh > 0 ? gh - 1 : 0),
                          $urandom, $urandom_range(0, 9) != 0);
            end else if (sel < 45) begin
                load_cell($urandom_range(0, 255), $urandom_range(0, 255), $urandom,
                          1'($urandom));
            end else if (sel < 90) begin
                // positions in half cells, from 256 cells below the grid up to 256 times its size, then into world
                logic signed [63:0] px, py;
                px = $signed($urandom_range(0, (gw + 1) * 512)) - 512;
                py = $signed($urandom_range(0, (gh + 1) * 512)) - 512;
                if (inv_x == 0 || inv_y == 0) sample_at($urandom, $urandom);
                else sample_at(32'(org_x + (px * 128 * 65536) / inv_x),
                               32'(org_y + (py * 128 * 65536) / inv_y));
            end else begin
                sample_at($urandom, $urandom);
            end
        end
    endtask

    task automatic test_random();
        random_phase(300, 4, 4, 32'h0001_0000, 32'h0001_0000);
        random_phase(300, 2, 3, 32'h0000_8000, 32'hFFFF_0000);
        random_phase(300, 16, 8, 32'h0003_0000, 32'h0002_4000);
        random_phase(250, 1, 1, 32'h0001_0000, 32'h0001_0000);
        random_phase(250, 256, 256, 32'h0000_0100, 32'hFFFF_FF00);
        random_phase(200, 5, 7, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    // receiver stalls while the sender keeps offering items
    task automatic test_backpressure();
        long_gaps = 1'b0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(160, 4, 4, 32'h0001_0000, 32'h0001_0000);
        join
        long_gaps = 1'b1;
    endtask

    // receiver
    always @(posedge aclk) begin
        int n;
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            n = $urandom_range(0, 99);
            m_ready <= (n < 60) || (n < 97 && m_ready);
        end
    end

    // result checker
    always @(posedge aclk) begin
        sample_res_t want;
        if (aresetn && m_valid && m_ready) begin
            samples_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
                want = expected_q.pop_front();
                if (m_hit !== want.hit || m_used_nearest !== want.used_nearest ||
                    m_height_out !== want.height) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0b nearest %0b height %h, got %0b %0b %h",
                                 want.hit, want.used_nearest, want.height,
                                 m_hit, m_used_nearest, m_height_out);
                end
            end
        end
    end

    // watchdog: the clearing sweep after reset is well inside this limit
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        org_x = 0;
        org_y = 0;
        inv_x = 65536;
        inv_y = 65536;
        size_w = 256;
        size_h = 256;
        foreach (grid_ok[i]) grid_ok[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        drain();
        $display("ran %0d loads and %0d samples over several grid settings, with backpressure",
                 loads_sent, samples_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
